### src/tmcg_pkg.sv
package tmcg_pkg;

  // default geometry and memory sizes
  localparam int TEXT_COLUMNS_DEF    = 64;
  localparam int TEXT_ROWS_DEF       = 24;
  localparam int LINES_PER_ROW_DEF   = 10;
  localparam int PIXELS_PER_CELL_DEF = 6;
  localparam int DISPLAY_DEPTH_DEF   = 2048;
  localparam int GLYPH_DEPTH_DEF     = 1024;

  // counter widths sized for the largest legal geometry
  localparam int PIC_W  = 3;   // pixel within cell, up to 8 pixels
  localparam int COL_W  = 7;   // up to 128 columns
  localparam int LINE_W = 4;   // up to 16 lines per row
  localparam int ROW_W  = 5;   // up to 32 rows
  localparam int SCAN_W = 9;   // up to 512 scan lines
  localparam int X_W    = 10;  // up to 1024 pixels per line
  localparam int ADDR_W = 12;  // widest memory address (4096 entries)

  localparam int GLYPH_ROWS = 8;
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = 2;
  localparam int OUT_CNT_W  = 3;

  localparam logic [1:0] CMD_WRITE_DISPLAY = 2'd0;
  localparam logic [1:0] CMD_WRITE_GLYPH   = 2'd1;
  localparam logic [1:0] CMD_PIXEL_TICK    = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [10:0] mem_address;
    logic [7:0]  mem_data;
  } cmd_item_t;

  typedef struct packed {
    logic       pixel_value;
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic       frame_end;
  } pix_item_t;

  // raster position handed from the scan counters to the fetch pipeline
  typedef struct packed {
    logic [ADDR_W-1:0] disp_addr;
    logic [LINE_W-1:0] line;
    logic [PIC_W-1:0]  pic;
    logic [X_W-1:0]    x;
    logic [SCAN_W-1:0] y;
    logic              last;
  } scan_pos_t;

  // remainder by a memory depth, restoring subtract over six steps
  function automatic logic [ADDR_W-1:0] reduce_mod(input logic [ADDR_W-1:0] value,
                                                   input logic [ADDR_W:0]   modulus);
    logic [ADDR_W+5:0] rem;
    logic [ADDR_W+5:0] step;
    rem = (ADDR_W+6)'(value);
    for (int k = 5; k >= 0; k--) begin
      step = (ADDR_W+6)'(modulus) << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[ADDR_W-1:0];
  endfunction

endpackage

### src/text_mode_character_generator_core.sv
// channel  signals                     direction  carries
// -------  --------------------------  ---------  ------------------------------------
// cmd      cmd_valid, cmd_ready, cmd   in         memory writes and pixel ticks
// pix      pix_valid, pix_ready, pix   out        one pixel item per pixel tick
//
// one item per cycle while cmd_ready is high; a pixel tick goes through display read,
// glyph read and pixel select to the out queue; write commands finish on the cycle taken
// after reset both memories are swept to zero, and cmd_ready stays low during the sweep
// the fetch pipeline never stalls; a 4-entry output queue absorbs pix backpressure and
// in run, cmd_ready drops only when ticks in flight plus queued pixels fill that queue
module text_mode_character_generator_core #(
  parameter int TEXT_COLUMNS    = tmcg_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS       = tmcg_pkg::TEXT_ROWS_DEF,
  parameter int LINES_PER_ROW   = tmcg_pkg::LINES_PER_ROW_DEF,
  parameter int PIXELS_PER_CELL = tmcg_pkg::PIXELS_PER_CELL_DEF,
  parameter int DISPLAY_DEPTH   = tmcg_pkg::DISPLAY_DEPTH_DEF,
  parameter int GLYPH_DEPTH     = tmcg_pkg::GLYPH_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  tmcg_pkg::cmd_item_t cmd,
  output logic                pix_valid,
  input  logic                pix_ready,
  output tmcg_pkg::pix_item_t pix
);

  localparam int DAW       = $clog2(DISPLAY_DEPTH);
  localparam int GAW       = $clog2(GLYPH_DEPTH);
  localparam int CLEAR_LEN = (DISPLAY_DEPTH > GLYPH_DEPTH) ? DISPLAY_DEPTH : GLYPH_DEPTH;
  localparam int CLR_W     = $clog2(CLEAR_LEN);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLEAR_LEN - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t                  state;
  logic [CLR_W-1:0]        clr_addr;

  // memories
  logic [7:0]              disp_mem [DISPLAY_DEPTH];
  logic [7:0]              glyph_mem [GLYPH_DEPTH];
  logic [7:0]              code_q;      // display read data, lines up with stage 1
  logic [7:0]              glyph_q;     // glyph read data, lines up with stage 2

  logic                    accept;
  logic                    tick;
  logic                    disp_we;
  logic                    glyph_we;
  logic [DAW-1:0]          disp_waddr;
  logic [GAW-1:0]          glyph_waddr;
  logic [7:0]              disp_wdata;
  logic [7:0]              glyph_wdata;
  logic [GAW-1:0]          glyph_raddr;
  logic [tmcg_pkg::ADDR_W-1:0] glyph_sum;
  logic [tmcg_pkg::ADDR_W-1:0] disp_wmod;
  logic [tmcg_pkg::ADDR_W-1:0] glyph_wmod;
  logic [tmcg_pkg::ADDR_W-1:0] glyph_rmod;

  tmcg_pkg::scan_pos_t     pos;

  // fetch pipeline: stage 1 waits on the code, stage 2 on the glyph row
  logic                    v1;
  tmcg_pkg::scan_pos_t     s1;
  logic                    v2;
  tmcg_pkg::scan_pos_t     s2;
  logic                    invert2;

  logic                    fg;
  tmcg_pkg::pix_item_t     pix_next;
  logic [tmcg_pkg::OUT_CNT_W-1:0] fifo_count;
  logic [tmcg_pkg::OUT_CNT_W-1:0] outstanding;

  // ---------------------------------------------------------------------------
  // handshake: room for every tick already in flight plus this one
  // ---------------------------------------------------------------------------
  assign outstanding = fifo_count + tmcg_pkg::OUT_CNT_W'(v1) + tmcg_pkg::OUT_CNT_W'(v2);
  assign cmd_ready   = (state == ST_RUN) &&
                       (outstanding < tmcg_pkg::OUT_CNT_W'(tmcg_pkg::OUT_DEPTH));
  assign accept      = cmd_valid && cmd_ready;
  assign tick        = accept && (cmd.command == tmcg_pkg::CMD_PIXEL_TICK);

  // ---------------------------------------------------------------------------
  // reset sweep
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // write ports: sweep zeros, or the command's byte at its reduced address
  // ---------------------------------------------------------------------------
  assign disp_wmod  = tmcg_pkg::reduce_mod(tmcg_pkg::ADDR_W'(cmd.mem_address),
                                           (tmcg_pkg::ADDR_W+1)'(DISPLAY_DEPTH));
  assign glyph_wmod = tmcg_pkg::reduce_mod(tmcg_pkg::ADDR_W'(cmd.mem_address),
                                           (tmcg_pkg::ADDR_W+1)'(GLYPH_DEPTH));

  always_comb begin
    if (state == ST_CLEAR) begin
      disp_we     = ({1'b0, clr_addr} < (CLR_W+1)'(DISPLAY_DEPTH));
      glyph_we    = ({1'b0, clr_addr} < (CLR_W+1)'(GLYPH_DEPTH));
      disp_waddr  = clr_addr[DAW-1:0];
      glyph_waddr = clr_addr[GAW-1:0];
      disp_wdata  = '0;
      glyph_wdata = '0;
    end else begin
      disp_we     = accept && (cmd.command == tmcg_pkg::CMD_WRITE_DISPLAY);
      glyph_we    = accept && (cmd.command == tmcg_pkg::CMD_WRITE_GLYPH);
      disp_waddr  = disp_wmod[DAW-1:0];
      glyph_waddr = glyph_wmod[GAW-1:0];
      disp_wdata  = cmd.mem_data;
      glyph_wdata = cmd.mem_data;
    end
  end

  // ---------------------------------------------------------------------------
  // scan counters and display read; writes land on the edge they are taken,
  // so every read sees exactly the writes that came before its tick
  // ---------------------------------------------------------------------------
  tmcg_scan #(
    .TEXT_COLUMNS    (TEXT_COLUMNS),
    .TEXT_ROWS       (TEXT_ROWS),
    .LINES_PER_ROW   (LINES_PER_ROW),
    .PIXELS_PER_CELL (PIXELS_PER_CELL),
    .DISPLAY_DEPTH   (DISPLAY_DEPTH)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .advance (tick),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (disp_we) begin
      disp_mem[disp_waddr] <= disp_wdata;
    end
    code_q <= disp_mem[pos.disp_addr[DAW-1:0]];
  end

  // glyph entry: 7-bit code times 8 plus the line, reduced to the glyph depth;
  // a glyph write taken on the same edge belongs to a later item, so read-first is right
  assign glyph_sum   = {2'b00, code_q[6:0], 3'b000} + tmcg_pkg::ADDR_W'(s1.line);
  assign glyph_rmod  = tmcg_pkg::reduce_mod(glyph_sum, (tmcg_pkg::ADDR_W+1)'(GLYPH_DEPTH));
  assign glyph_raddr = glyph_rmod[GAW-1:0];

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_waddr] <= glyph_wdata;
    end
    glyph_q <= glyph_mem[glyph_raddr];
  end

  // ---------------------------------------------------------------------------
  // pipeline registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= tick;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s1      <= pos;
    s2      <= s1;
    invert2 <= code_q[7];
  end

  // glyph bits go out msb first; the spacing lines below the glyph are background
  always_comb begin
    fg = 1'b0;
    if (s2.line < tmcg_pkg::LINE_W'(tmcg_pkg::GLYPH_ROWS)) begin
      fg = glyph_q[~s2.pic];
    end
    pix_next.pixel_value = fg ^ invert2;
    pix_next.pixel_x     = s2.x[8:0];
    pix_next.pixel_y     = s2.y[7:0];
    pix_next.frame_end   = s2.last;
  end

  tmcg_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (v2),
    .push_data (pix_next),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .count     (fifo_count)
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    outstanding <= tmcg_pkg::OUT_CNT_W'(tmcg_pkg::OUT_DEPTH))
    else $error("output queue overcommitted");

  a_idle_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !cmd_ready)
    else $error("command taken during memory sweep");

  a_tick_enters: assert property (@(posedge clk) disable iff (rst)
    tick |=> ##1 v2)
    else $error("pixel tick lost in fetch pipeline");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("pixel appeared without a tick");

endmodule

### src/tmcg_scan.sv
module tmcg_scan #(
  parameter int TEXT_COLUMNS    = tmcg_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS       = tmcg_pkg::TEXT_ROWS_DEF,
  parameter int LINES_PER_ROW   = tmcg_pkg::LINES_PER_ROW_DEF,
  parameter int PIXELS_PER_CELL = tmcg_pkg::PIXELS_PER_CELL_DEF,
  parameter int DISPLAY_DEPTH   = tmcg_pkg::DISPLAY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  output tmcg_pkg::scan_pos_t pos
);

  localparam int DAW = $clog2(DISPLAY_DEPTH);
  localparam logic [tmcg_pkg::PIC_W-1:0]  PIC_LAST  = tmcg_pkg::PIC_W'(PIXELS_PER_CELL - 1);
  localparam logic [tmcg_pkg::COL_W-1:0]  COL_LAST  = tmcg_pkg::COL_W'(TEXT_COLUMNS - 1);
  localparam logic [tmcg_pkg::LINE_W-1:0] LINE_LAST = tmcg_pkg::LINE_W'(LINES_PER_ROW - 1);
  localparam logic [tmcg_pkg::ROW_W-1:0]  ROW_LAST  = tmcg_pkg::ROW_W'(TEXT_ROWS - 1);
  localparam logic [DAW-1:0]              DISP_LAST = DAW'(DISPLAY_DEPTH - 1);

  logic [tmcg_pkg::PIC_W-1:0]  pic;
  logic [tmcg_pkg::COL_W-1:0]  col;
  logic [tmcg_pkg::LINE_W-1:0] line;
  logic [tmcg_pkg::ROW_W-1:0]  row;
  logic [tmcg_pkg::SCAN_W-1:0] scan_line;
  logic [tmcg_pkg::X_W-1:0]    x;
  logic [DAW-1:0]              disp_addr;
  logic [DAW-1:0]              row_base;
  logic [DAW-1:0]              disp_inc;

  // next display entry, wrapping at the memory depth
  assign disp_inc = (disp_addr == DISP_LAST) ? '0 : disp_addr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pic       <= '0;
      col       <= '0;
      line      <= '0;
      row       <= '0;
      scan_line <= '0;
      x         <= '0;
      disp_addr <= '0;
      row_base  <= '0;
    end else if (advance) begin
      if (pic == PIC_LAST) begin
        pic <= '0;
        if (col == COL_LAST) begin
          col <= '0;
          x   <= '0;
          if (line == LINE_LAST) begin
            line <= '0;
            if (row == ROW_LAST) begin
              row       <= '0;
              scan_line <= '0;
              row_base  <= '0;
              disp_addr <= '0;
            end else begin
              row       <= row + 1'b1;
              scan_line <= scan_line + 1'b1;
              row_base  <= disp_inc;
              disp_addr <= disp_inc;
            end
          end else begin
            line      <= line + 1'b1;
            scan_line <= scan_line + 1'b1;
            disp_addr <= row_base;
          end
        end else begin
          col       <= col + 1'b1;
          x         <= x + 1'b1;
          disp_addr <= disp_inc;
        end
      end else begin
        pic <= pic + 1'b1;
        x   <= x + 1'b1;
      end
    end
  end

  always_comb begin
    pos.disp_addr = tmcg_pkg::ADDR_W'(disp_addr);
    pos.line      = line;
    pos.pic       = pic;
    pos.x         = x;
    pos.y         = scan_line;
    pos.last      = (pic == PIC_LAST) && (col == COL_LAST) &&
                    (line == LINE_LAST) && (row == ROW_LAST);
  end

endmodule

### src/tmcg_out_fifo.sv
module tmcg_out_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  tmcg_pkg::pix_item_t                 push_data,
  output logic                                pix_valid,
  input  logic                                pix_ready,
  output tmcg_pkg::pix_item_t                 pix,
  output logic [tmcg_pkg::OUT_CNT_W-1:0]      count
);

  tmcg_pkg::pix_item_t              slots [tmcg_pkg::OUT_DEPTH];
  logic [tmcg_pkg::OUT_PTR_W-1:0]   wr_ptr;
  logic [tmcg_pkg::OUT_PTR_W-1:0]   rd_ptr;
  logic                             pop;

  assign pix_valid = (count != '0);
  assign pix       = slots[rd_ptr];
  assign pop       = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + tmcg_pkg::OUT_CNT_W'(push) - tmcg_pkg::OUT_CNT_W'(pop);
    end
  end

endmodule

### tb/sv/text_mode_character_generator_core_tb.sv
module text_mode_character_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int DRAIN_CYCLES = 20;

  // raster geometry of the default build
  localparam int LINE_PIXELS  = tmcg_pkg::TEXT_COLUMNS_DEF * tmcg_pkg::PIXELS_PER_CELL_DEF;
  localparam int TOTAL_LINES  = tmcg_pkg::TEXT_ROWS_DEF * tmcg_pkg::LINES_PER_ROW_DEF;
  localparam int FRAME_PIXELS = LINE_PIXELS * TOTAL_LINES;

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_ready;
  tmcg_pkg::cmd_item_t cmd = '0;
  logic                pix_valid;
  logic                pix_ready = 1'b0;
  tmcg_pkg::pix_item_t pix;

  // items waiting to be offered, and pixels predicted but not yet seen
  tmcg_pkg::cmd_item_t cmd_backlog[$];
  tmcg_pkg::pix_item_t predicted_pixels[$];

  // idle rates in percent for the command sender and the pixel receiver
  int send_idle_pct = 35;
  int recv_idle_pct = 85;
  int mismatch_count = 0;

  // raster position of the next tick to be queued, used to aim writes at it
  int plan_pix = 0;

  // shadow state of the block
  logic [7:0] shadow_display[tmcg_pkg::DISPLAY_DEPTH_DEF];
  logic [7:0] shadow_glyph[tmcg_pkg::GLYPH_DEPTH_DEF];
  int         shadow_pic = 0;
  int         shadow_col = 0;
  int         shadow_scan = 0;

  text_mode_character_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // apply one accepted item to the shadow state; a tick yields the pixel under the beam
  function automatic void render_command(input tmcg_pkg::cmd_item_t c);
    int                  row;
    int                  line;
    logic [7:0]          code;
    logic [7:0]          glyph_row;
    logic                fg;
    tmcg_pkg::pix_item_t p;
    case (c.command)
      tmcg_pkg::CMD_WRITE_DISPLAY: begin
        shadow_display[c.mem_address % tmcg_pkg::DISPLAY_DEPTH_DEF] = c.mem_data;
      end
      tmcg_pkg::CMD_WRITE_GLYPH: begin
        shadow_glyph[c.mem_address % tmcg_pkg::GLYPH_DEPTH_DEF] = c.mem_data;
      end
      tmcg_pkg::CMD_PIXEL_TICK: begin
        row = shadow_scan / tmcg_pkg::LINES_PER_ROW_DEF;
        line = shadow_scan % tmcg_pkg::LINES_PER_ROW_DEF;
        code = shadow_display[(row * tmcg_pkg::TEXT_COLUMNS_DEF + shadow_col) %
                              tmcg_pkg::DISPLAY_DEPTH_DEF];
        glyph_row = shadow_glyph[(code[6:0] * tmcg_pkg::GLYPH_ROWS + line) %
                                 tmcg_pkg::GLYPH_DEPTH_DEF];
        // gap lines below the glyph show background, bit 7 inverts the cell
        fg = (line < tmcg_pkg::GLYPH_ROWS) ? glyph_row[7 - shadow_pic] : 1'b0;
        p.pixel_value = fg ^ code[7];
        p.pixel_x = 9'(shadow_col * tmcg_pkg::PIXELS_PER_CELL_DEF + shadow_pic);
        p.pixel_y = 8'(shadow_scan);
        p.frame_end = (shadow_pic == tmcg_pkg::PIXELS_PER_CELL_DEF - 1) &&
                      (shadow_col == tmcg_pkg::TEXT_COLUMNS_DEF - 1) &&
                      (shadow_scan == TOTAL_LINES - 1);
        predicted_pixels.push_back(p);
        // pixel carries into column, column into scan line, scan line wraps per frame
        shadow_pic++;
        if (shadow_pic == tmcg_pkg::PIXELS_PER_CELL_DEF) begin
          shadow_pic = 0;
          shadow_col++;
          if (shadow_col == tmcg_pkg::TEXT_COLUMNS_DEF) begin
            shadow_col = 0;
            shadow_scan = (shadow_scan + 1) % TOTAL_LINES;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic queue_command(input logic [1:0] op, input logic [10:0] addr,
                               input logic [7:0] data);
    tmcg_pkg::cmd_item_t c;
    c.command = op;
    c.mem_address = addr;
    c.mem_data = data;
    cmd_backlog.push_back(c);
    if (op == tmcg_pkg::CMD_PIXEL_TICK) plan_pix = (plan_pix + 1) % FRAME_PIXELS;
  endtask

  // address and data are don't-care on a tick, so keep them moving
  task automatic queue_tick();
    queue_command(tmcg_pkg::CMD_PIXEL_TICK, 11'($urandom), 8'($urandom));
  endtask

  // mostly cell bursts: write the code of the cell under the beam, the glyph row it
  // will fetch, then tick through all or part of the cell; the rest is unrelated noise
  task automatic queue_random_mix(input int n_items);
    int         count;
    int         pos;
    int         scan;
    int         col;
    int         line;
    int         left;
    int         ticks;
    logic [7:0] code;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(99) < 25) begin
        queue_command(2'($urandom_range(3)), 11'($urandom), 8'($urandom));
        count++;
      end else begin
        pos = plan_pix % LINE_PIXELS;
        scan = plan_pix / LINE_PIXELS;
        col = pos / tmcg_pkg::PIXELS_PER_CELL_DEF;
        line = scan % tmcg_pkg::LINES_PER_ROW_DEF;
        left = tmcg_pkg::PIXELS_PER_CELL_DEF - pos % tmcg_pkg::PIXELS_PER_CELL_DEF;
        code = 8'($urandom);
        queue_command(tmcg_pkg::CMD_WRITE_DISPLAY,
                      11'((scan / tmcg_pkg::LINES_PER_ROW_DEF) * tmcg_pkg::TEXT_COLUMNS_DEF +
                          col), code);
        count++;
        if (line < tmcg_pkg::GLYPH_ROWS) begin
          // top address bit aliases onto the same glyph entry
          queue_command(tmcg_pkg::CMD_WRITE_GLYPH,
                        {1'($urandom), 10'(code[6:0] * tmcg_pkg::GLYPH_ROWS + line)},
                        8'($urandom));
          count++;
        end
        ticks = ($urandom_range(3) == 0) ? $urandom_range(left, 1) : left;
        repeat (ticks) queue_tick();
        count += ticks;
      end
    end
  endtask

  // wait at the falling edge until every queued item is taken and every pixel seen
  task automatic drain_all();
    while (cmd_backlog.size() != 0 || cmd_valid || predicted_pixels.size() != 0)
      @(negedge clk);
  endtask

  // command sender: offers the next item when the channel is free, predicts on accept
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) render_command(cmd);
      if (!cmd_valid || cmd_ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // pixel receiver: compares each taken item with the oldest prediction
  always @(posedge clk) begin
    tmcg_pkg::pix_item_t want;
    if (rst) begin
      pix_ready <= 1'b0;
    end else begin
      if (pix_valid && pix_ready) begin
        if (predicted_pixels.size() == 0) begin
          $display("%0t: unexpected pixel item, got value=%b x=%0d y=%0d end=%b",
                   $time, pix.pixel_value, pix.pixel_x, pix.pixel_y, pix.frame_end);
          mismatch_count++;
        end else begin
          want = predicted_pixels.pop_front();
          if (pix !== want) begin
            $display("%0t: expected v=%b x=%0d y=%0d end=%b, got v=%b x=%0d y=%0d end=%b",
                     $time, want.pixel_value, want.pixel_x, want.pixel_y, want.frame_end,
                     pix.pixel_value, pix.pixel_x, pix.pixel_y, pix.frame_end);
            mismatch_count++;
          end
        end
      end
      pix_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    foreach (shadow_display[i]) shadow_display[i] = 8'h00;
    foreach (shadow_glyph[i]) shadow_glyph[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: invert bit, glyph alias through address bit 10, top entries,
    // ignored command, glyph 127, and a cell left at its reset code
    queue_command(tmcg_pkg::CMD_WRITE_DISPLAY, 11'h000, 8'h81);
    queue_command(tmcg_pkg::CMD_WRITE_GLYPH, 11'h008, 8'hA5);
    queue_command(tmcg_pkg::CMD_WRITE_GLYPH, 11'h408, 8'h5A);
    queue_command(tmcg_pkg::CMD_WRITE_DISPLAY, 11'h7FF, 8'hFF);
    queue_command(tmcg_pkg::CMD_WRITE_GLYPH, 11'h3FF, 8'hFF);
    queue_command(CMD_UNUSED, 11'h000, 8'hFF);
    repeat (tmcg_pkg::PIXELS_PER_CELL_DEF) queue_tick();
    queue_command(tmcg_pkg::CMD_WRITE_DISPLAY, 11'h001, 8'h7F);
    queue_command(tmcg_pkg::CMD_WRITE_GLYPH, 11'h3F8, 8'h80);
    repeat (tmcg_pkg::PIXELS_PER_CELL_DEF) queue_tick();
    queue_command(CMD_UNUSED, 11'h7FF, 8'h00);
    queue_tick();
    queue_random_mix(350);
    drain_all();

    // receiver mostly ready, sender sparse
    send_idle_pct = 85;
    recv_idle_pct = 35;
    queue_random_mix(350);
    drain_all();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_mix(350);
    drain_all();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // covers the memory sweep after reset and the slowest idling phases many times over
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
src/tmcg_pkg.sv
src/tmcg_scan.sv
src/tmcg_out_fifo.sv
src/text_mode_character_generator_core.sv
tb/sv/text_mode_character_generator_core_tb.sv
